@@ sv/pdctp_pkg.sv @@
`timescale 1ns / 1ps
// shared types and constants for the planar-diagram token parser
// no dependencies

package pdctp_pkg;

  localparam int LABEL_BITS_DEF = 32;
  localparam int TUPLE_SIZE     = 4;
  localparam int OUT_LABEL_W    = 32;
  localparam int RQ_DEPTH       = 4;
  localparam int RQ_PTR_W       = $clog2(RQ_DEPTH);
  localparam int RQ_CNT_W       = $clog2(RQ_DEPTH + 1);

  typedef enum logic [2:0] {
    MODE_IDLE    = 3'd0,
    MODE_NUM     = 3'd1,
    MODE_AFTER_P = 3'd2,
    MODE_AFTER_X = 3'd3,
    MODE_HALT    = 3'd4
  } mode_e;

  typedef enum logic [2:0] {
    KIND_TUPLE   = 3'd0,
    KIND_DONE    = 3'd1,
    KIND_BAD_SEP = 3'd2,
    KIND_BAD_INT = 3'd3,
    KIND_BAD_LEN = 3'd4
  } kind_e;

  typedef struct packed {
    kind_e                  kind;
    logic [OUT_LABEL_W-1:0] label_a;
    logic [OUT_LABEL_W-1:0] label_b;
    logic [OUT_LABEL_W-1:0] label_c;
    logic [OUT_LABEL_W-1:0] label_d;
    logic                   last;
  } result_t;

  typedef struct packed {
    mode_e mode;
    logic  halted;
  } scan_status_t;

  typedef struct packed {
    logic [RQ_CNT_W-1:0] count;
    logic                room;
  } rq_status_t;

endpackage

@@ sv/pd_code_token_parser_unit.sv @@
`timescale 1ns / 1ps
// top level of the planar-diagram token parser: scanner plus result queue
// depends on pdctp_pkg, pdctp_scan, pdctp_rq
// latency: a result enters the queue in the cycle after its input beat is taken, behind any older results
// throughput: one input beat per cycle while the queue has room; output carries one result per cycle
// while the sink is ready, so bytes that give two results are drained through a four-entry queue
// reset: async active low, scanner idle with empty count, queue empty

module pd_code_token_parser_unit #(
  parameter int LABEL_BITS = pdctp_pkg::LABEL_BITS_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                s_axis_tvalid_i,
  output logic                                s_axis_tready_o,
  input  logic [7:0]                          s_axis_tdata_i,  // text_byte
  input  logic                                s_axis_tlast_i,  // end_of_text
  output logic                                m_axis_tvalid_o,
  input  logic                                m_axis_tready_i,
  // label_a, label_b, label_c, label_d
  output logic [4*pdctp_pkg::OUT_LABEL_W-1:0] m_axis_tdata_o,
  output logic [2:0]                          m_axis_tuser_o,  // kind
  output logic                                m_axis_tlast_o   // final_result
);
  import pdctp_pkg::*;

  logic         in_acc;
  logic [1:0]   wr_n;
  result_t      wr0, wr1, head;
  scan_status_t scan_st;
  rq_status_t   rq_st;

  assign s_axis_tready_o = rq_st.room;
  assign in_acc          = s_axis_tvalid_i && s_axis_tready_o;

  pdctp_scan #(
    .LABEL_BITS(LABEL_BITS)
  ) u_scan (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .accept_i     (in_acc),
    .text_byte_i  (s_axis_tdata_i),
    .end_of_text_i(s_axis_tlast_i),
    .wr_n_o       (wr_n),
    .wr0_o        (wr0),
    .wr1_o        (wr1),
    .status_o     (scan_st)
  );

  pdctp_rq u_rq (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_n_i    (wr_n),
    .wr0_i     (wr0),
    .wr1_i     (wr1),
    .rd_valid_o(m_axis_tvalid_o),
    .rd_ready_i(m_axis_tready_i),
    .head_o    (head),
    .status_o  (rq_st)
  );

  assign m_axis_tdata_o = {head.label_d, head.label_c, head.label_b, head.label_a};
  assign m_axis_tuser_o = head.kind;
  assign m_axis_tlast_o = head.last;

  a_rq_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rq_st.count <= RQ_CNT_W'(RQ_DEPTH))
    else $error("result queue overrun");

  a_end_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && s_axis_tlast_i) |=> (m_axis_tvalid_o && (scan_st.mode == MODE_IDLE)))
    else $error("end of text did not rearm or give a result");

  a_labels_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && (m_axis_tuser_o != KIND_TUPLE)) |-> (m_axis_tdata_o == '0))
    else $error("labels set on a non-tuple result");

  a_halt_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && scan_st.halted && !s_axis_tlast_i) |-> (wr_n == 2'd0))
    else $error("result while halted");

endmodule

@@ sv/pdctp_scan.sv @@
`timescale 1ns / 1ps
// scanner: token state, number accumulator, held labels and result forming
// depends on pdctp_pkg

module pdctp_scan #(
  parameter int LABEL_BITS = pdctp_pkg::LABEL_BITS_DEF
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   accept_i,
  input  logic [7:0]             text_byte_i,
  input  logic                   end_of_text_i,
  output logic [1:0]             wr_n_o,
  output pdctp_pkg::result_t     wr0_o,
  output pdctp_pkg::result_t     wr1_o,
  output pdctp_pkg::scan_status_t status_o
);
  import pdctp_pkg::*;

  localparam int SLOT_W = $clog2(TUPLE_SIZE);
  localparam int PROD_W = LABEL_BITS + 4;
  localparam logic [SLOT_W-1:0] SLOT_LAST = SLOT_W'(TUPLE_SIZE - 1);

  localparam logic [7:0] CH_0     = 8'h30;
  localparam logic [7:0] CH_9     = 8'h39;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_CR    = 8'h0d;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_COMMA = 8'h2c;
  localparam logic [7:0] CH_LPAR  = 8'h28;
  localparam logic [7:0] CH_RPAR  = 8'h29;
  localparam logic [7:0] CH_LBRK  = 8'h5b;
  localparam logic [7:0] CH_RBRK  = 8'h5d;
  localparam logic [7:0] CH_LBRC  = 8'h7b;
  localparam logic [7:0] CH_RBRC  = 8'h7d;
  localparam logic [7:0] CH_P     = 8'h50;
  localparam logic [7:0] CH_D     = 8'h44;
  localparam logic [7:0] CH_X     = 8'h58;
  localparam logic [7:0] CH_LP    = 8'h70;
  localparam logic [7:0] CH_LM    = 8'h6d;

  mode_e                  mode_q, mode_d;
  logic [LABEL_BITS-1:0]  acc_q, acc_d;
  logic [SLOT_W-1:0]      slot_q, slot_d;
  logic [LABEL_BITS-1:0]  held_q [TUPLE_SIZE-1];

  logic                   is_digit, is_sep, fin_bad, held_we;
  logic [LABEL_BITS-1:0]  digit_val;
  logic [PROD_W-1:0]      prod;
  logic                   do_fin, do_scan;
  logic [2:0]             c_v;
  result_t                c_r [3];
  result_t                blank;

  assign is_digit  = (text_byte_i >= CH_0) && (text_byte_i <= CH_9);
  assign is_sep    = (text_byte_i == CH_SPACE) ||
                     ((text_byte_i >= CH_TAB) && (text_byte_i <= CH_CR)) ||
                     (text_byte_i == CH_COMMA) || (text_byte_i == CH_LPAR) ||
                     (text_byte_i == CH_RPAR) || (text_byte_i == CH_LBRK) ||
                     (text_byte_i == CH_RBRK) || (text_byte_i == CH_LBRC) ||
                     (text_byte_i == CH_RBRC);
  assign digit_val = LABEL_BITS'(text_byte_i[3:0]);
  assign prod      = PROD_W'({acc_q, 3'b000}) + PROD_W'({acc_q, 1'b0}) +
                     PROD_W'(digit_val);
  assign fin_bad   = (acc_q == '0) || (&acc_q);

  always_comb begin
    blank         = '0;
    blank.kind    = KIND_TUPLE;
    mode_d        = mode_q;
    acc_d         = acc_q;
    slot_d        = slot_q;
    held_we       = 1'b0;
    do_fin        = 1'b0;
    do_scan       = 1'b0;
    c_v           = '0;
    c_r[0]        = blank;
    c_r[1]        = blank;
    c_r[2]        = blank;
    if (accept_i) begin
      if (end_of_text_i) begin
        do_fin = (mode_q == MODE_NUM);
      end else begin
        unique case (mode_q)
          MODE_HALT: ;
          MODE_NUM: begin
            if (is_digit) begin
              // saturate at all-ones
              if (prod[PROD_W-1:LABEL_BITS] != '0) acc_d = '1;
              else acc_d = prod[LABEL_BITS-1:0];
            end else begin
              do_fin  = 1'b1;
              do_scan = !fin_bad;
            end
          end
          MODE_AFTER_P: begin
            if (text_byte_i == CH_D) mode_d = MODE_IDLE;
            else do_scan = 1'b1;
          end
          MODE_AFTER_X: begin
            if ((text_byte_i == CH_LP) || (text_byte_i == CH_LM)) mode_d = MODE_IDLE;
            else do_scan = 1'b1;
          end
          default: do_scan = 1'b1;
        endcase
      end

      if (do_fin) begin
        acc_d = '0;
        if (fin_bad) begin
          c_v[0]      = 1'b1;
          c_r[0].kind = KIND_BAD_INT;
          mode_d      = MODE_HALT;
        end else begin
          mode_d = MODE_IDLE;
          if (slot_q == SLOT_LAST) begin
            c_v[0]         = 1'b1;
            c_r[0].label_a = OUT_LABEL_W'(held_q[0]);
            c_r[0].label_b = OUT_LABEL_W'(held_q[1]);
            c_r[0].label_c = OUT_LABEL_W'(held_q[2]);
            c_r[0].label_d = OUT_LABEL_W'(acc_q);
            slot_d         = '0;
          end else begin
            held_we = 1'b1;
            slot_d  = slot_q + SLOT_W'(1);
          end
        end
      end

      if (do_scan) begin
        mode_d = MODE_IDLE;
        if (is_digit) begin
          mode_d = MODE_NUM;
          acc_d  = digit_val;
        end else if (is_sep) begin
          mode_d = MODE_IDLE;
        end else if (text_byte_i == CH_P) begin
          mode_d = MODE_AFTER_P;
        end else if (text_byte_i == CH_X) begin
          mode_d = MODE_AFTER_X;
        end else begin
          c_v[1]      = 1'b1;
          c_r[1].kind = KIND_BAD_SEP;
          mode_d      = MODE_HALT;
        end
      end

      if (end_of_text_i) begin
        if ((mode_d != MODE_HALT) && (slot_d != '0)) begin
          c_v[1]      = 1'b1;
          c_r[1].kind = KIND_BAD_LEN;
        end
        c_v[2]      = 1'b1;
        c_r[2].kind = KIND_DONE;
        mode_d      = MODE_IDLE;
        acc_d       = '0;
        slot_d      = '0;
      end
    end
  end

  // pack the candidates into at most two results, last one flagged
  always_comb begin
    wr0_o  = c_v[0] ? c_r[0] : (c_v[1] ? c_r[1] : c_r[2]);
    wr1_o  = (c_v[0] && c_v[1]) ? c_r[1] : c_r[2];
    wr_n_o = 2'(c_v[0]) + 2'(c_v[1]) + 2'(c_v[2]);
    wr0_o.last = (wr_n_o == 2'd1);
    wr1_o.last = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= MODE_IDLE;
      acc_q  <= '0;
      slot_q <= '0;
    end else begin
      mode_q <= mode_d;
      acc_q  <= acc_d;
      slot_q <= slot_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (held_we) begin
      held_q[slot_q] <= acc_q;
    end
  end

  assign status_o.mode   = mode_q;
  assign status_o.halted = (mode_q == MODE_HALT);

endmodule

@@ sv/pdctp_rq.sv @@
`timescale 1ns / 1ps
// result queue: takes up to two results a cycle, hands out one beat a cycle while the reader is ready
// depends on pdctp_pkg

module pdctp_rq (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic [1:0]            wr_n_i,
  input  pdctp_pkg::result_t    wr0_i,
  input  pdctp_pkg::result_t    wr1_i,
  output logic                  rd_valid_o,
  input  logic                  rd_ready_i,
  output pdctp_pkg::result_t    head_o,
  output pdctp_pkg::rq_status_t status_o
);
  import pdctp_pkg::*;

  result_t               mem_q [RQ_DEPTH];
  logic [RQ_PTR_W-1:0]   wp_q, wp_d, rp_q, rp_d;
  logic [RQ_CNT_W-1:0]   cnt_q, cnt_d;
  logic                  rd;

  assign rd_valid_o = (cnt_q != '0);
  assign rd         = rd_valid_o && rd_ready_i;
  assign head_o     = mem_q[rp_q];

  assign wp_d  = wp_q + RQ_PTR_W'(wr_n_i);
  assign rp_d  = rp_q + RQ_PTR_W'(rd);
  assign cnt_d = cnt_q + RQ_CNT_W'(wr_n_i) - RQ_CNT_W'(rd);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= '0;
      rp_q  <= '0;
      cnt_q <= '0;
    end else begin
      wp_q  <= wp_d;
      rp_q  <= rp_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_n_i != 2'd0) begin
      mem_q[wp_q] <= wr0_i;
    end
    if (wr_n_i == 2'd2) begin
      mem_q[wp_q + RQ_PTR_W'(1)] <= wr1_i;
    end
  end

  assign status_o.count = cnt_q;
  // room for the worst case of two results from one beat
  assign status_o.room  = (cnt_q <= RQ_CNT_W'(RQ_DEPTH - 2));

endmodule
